>>> design/bsm_pkg.sv
// Package for the bounding sphere merge block: payload structs, widths and the state encoding.
// No dependencies.
package bsm_pkg;

   localparam int CoordWidth  = 32;
   localparam int RadiusWidth = 31;
   localparam int MinDistWidth = 16;

   typedef struct packed {
      logic signed [CoordWidth-1:0] center_x;
      logic signed [CoordWidth-1:0] center_y;
      logic signed [CoordWidth-1:0] center_z;
      logic [RadiusWidth-1:0]       sphere_radius;
   } req_word_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] merged_x;
      logic signed [CoordWidth-1:0] merged_y;
      logic signed [CoordWidth-1:0] merged_z;
      logic [RadiusWidth-1:0]       merged_radius;
   } rsp_word_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_SQX   = 9'b000000010,
      ST_SQY   = 9'b000000100,
      ST_SQZ   = 9'b000001000,
      ST_TEST  = 9'b000010000,
      ST_SQRT  = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_SCALE = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

endpackage

>>> design/bsm_serial_mul.sv
// Bit-serial 33 x 33 unsigned multiplier, one multiplier bit per cycle.
// Uses bsm_pkg only for the house conventions; no submodules.
module bsm_serial_mul
   import bsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] op_a,
   input  logic [32:0] op_b,
   output logic        done,
   output logic [65:0] product
);

   logic [65:0] acc_ff, acc_in;
   logic [65:0] mcand_ff, mcand_in;
   logic [32:0] mplier_ff, mplier_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      count_in  = count_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = {33'd0, op_a};
         mplier_in = op_b;
         count_in  = 6'd33;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         count_in  = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

>>> design/bounding_sphere_merge.sv
// Top level of the bounding sphere merge block: sequencer, serial sqrt and divide.
// Depends on bsm_pkg and bsm_serial_mul.
//
//  channel  direction  ports
//  req      in         req_valid, req_ready, req_data
//  rsp      out        rsp_valid, rsp_ready, rsp_data
//  csr      in         csr_write, csr_wdata (min_distance)
//
// One word at a time. Each square runs on the serial multiplier (start,
// multiplier bits, done), the square root yields one result bit per step, then
// come the ratio by serial divide and each axis shift on the multiplier.
// rsp_valid rises soonest when one sphere holds the other, later without a
// shift, latest with one. Reset is synchronous and clears the kept sphere. A
// stalled rsp holds the result; the next req word is taken only once it has left.
module bounding_sphere_merge
   import bsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_write,
   input  logic [MinDistWidth-1:0] csr_wdata
);

   state_type state_ff, state_in;
   logic signed [32:0] kx_ff, ky_ff, kz_ff, kx_in, ky_in, kz_in;
   logic [30:0] kr_ff, kr_in;
   logic signed [32:0] nx_ff, ny_ff, nz_ff, nx_in, ny_in, nz_in;
   logic [30:0] nr_ff, nr_in;
   logic [65:0] ssum_ff, ssum_in;
   logic [65:0] rem_ff, rem_in;       // sqrt remainder / divide remainder
   logic [32:0] root_ff, root_in;     // sqrt result, then the divisor of the ratio
   logic [32:0] quo_ff, quo_in;
   logic [33:0] rsum_ff, rsum_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  axis_ff, axis_in;
   logic        mstart_ff, mstart_in;
   logic [MinDistWidth-1:0] mind_ff;
   logic        rspv_ff, rspv_in;

   logic        mdone;
   logic [65:0] mprod;
   logic [32:0] ma, mb;
   logic signed [32:0] dsel;
   logic [32:0] dmag;

   always_comb begin
      unique case (axis_ff)
         2'd0:    dsel = kx_ff - nx_ff;
         2'd1:    dsel = ky_ff - ny_ff;
         default: dsel = kz_ff - nz_ff;
      endcase
      dmag = dsel[32] ? 33'(-dsel) : dsel;
      ma   = dmag;
      mb   = (state_ff == ST_SCALE) ? quo_ff : dmag;
   end

   bsm_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mstart_ff),
      .op_a    (ma),
      .op_b    (mb),
      .done    (mdone),
      .product (mprod)
   );

   logic [31:0] rdiff;
   logic [65:0] rsq;
   logic [66:0] trial;
   logic [33:0] dtrial;
   logic [33:0] k;
   logic [32:0] shamt;
   logic signed [32:0] shifted;

   function automatic logic signed [32:0] nx_sel();
      unique case (axis_ff)
         2'd0:    return nx_ff;
         2'd1:    return ny_ff;
         default: return nz_ff;
      endcase
   endfunction

   always_comb begin
      rdiff = (kr_ff >= nr_ff) ? 32'(kr_ff - nr_ff) : 32'(nr_ff - kr_ff);
      rsq   = 66'(rdiff) * 66'(rdiff);
      // restoring sqrt on two bits of the radicand per step
      trial = {rem_ff[64:0], ssum_ff[65:64]} - {32'd0, root_ff, 2'b01};
      dtrial = {rem_ff[32:0], 1'b0} - {1'b0, root_ff};
      k = (rsum_ff >= {3'd0, nr_ff}) ? rsum_ff - {3'd0, nr_ff} : '0;
      shamt = mprod[64:32];
      shifted = dsel[32] ? nx_sel() - $signed(shamt) : nx_sel() + $signed(shamt);
   end

   always_comb begin
      state_in = state_ff;
      kx_in = kx_ff; ky_in = ky_ff; kz_in = kz_ff; kr_in = kr_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff; nr_in = nr_ff;
      ssum_in = ssum_ff; rem_in = rem_ff; root_in = root_ff; quo_in = quo_ff;
      rsum_in = rsum_ff; cnt_in = cnt_ff; axis_in = axis_ff;
      mstart_in = 1'b0;
      rspv_in = rspv_ff;
      if (rspv_ff && rsp_ready) rspv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !rspv_ff) begin
               nx_in = 33'(req_data.center_x);
               ny_in = 33'(req_data.center_y);
               nz_in = 33'(req_data.center_z);
               nr_in = req_data.sphere_radius;
               ssum_in = '0;
               axis_in = 2'd0;
               mstart_in = 1'b1;
               state_in = ST_SQX;
            end
         end
         ST_SQX, ST_SQY, ST_SQZ: begin
            if (mdone) begin
               ssum_in = ssum_ff + mprod;
               if (state_ff == ST_SQZ) begin
                  state_in = ST_TEST;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  mstart_in = 1'b1;
                  state_in = (state_ff == ST_SQX) ? ST_SQY : ST_SQZ;
               end
            end
         end
         ST_TEST: begin
            if (rsq >= ssum_ff) begin
               if (kr_ff < nr_ff) begin
                  kr_in = nr_ff; kx_in = nx_ff; ky_in = ny_ff; kz_in = nz_ff;
               end
               state_in = ST_DONE;
            end else begin
               rem_in = '0; root_in = '0; cnt_in = 6'd33;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            ssum_in = ssum_ff << 2;
            if (!trial[66]) begin
               rem_in  = trial[65:0];
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               rem_in  = {rem_ff[63:0], ssum_ff[65:64]};
               root_in = {root_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               rsum_in = (34'(root_in) + 34'(nr_ff) + 34'(kr_ff)) >> 1;
               kr_in = (rsum_in > 34'h7FFFFFFF) ? 31'h7FFFFFFF : rsum_in[30:0];
               // keep the old centre through the shift, it sets the deltas
               if (root_in > 33'(mind_ff)) begin
                  state_in = ST_DIV;
               end else begin
                  kx_in = nx_ff; ky_in = ny_ff; kz_in = nz_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            // first step saturates the ratio or loads k; root_ff is the divisor
            if (cnt_ff == 6'd0) begin
               if ({1'b0, k} >= {2'b0, root_ff}) begin
                  quo_in = 33'h100000000;
                  axis_in = 2'd0; mstart_in = 1'b1; state_in = ST_SCALE;
               end else begin
                  rem_in = {32'd0, k}; quo_in = '0; cnt_in = 6'd32;
               end
            end else begin
               if (!dtrial[33]) begin
                  rem_in = {32'd0, dtrial};
                  quo_in = {quo_ff[31:0], 1'b1};
               end else begin
                  rem_in = {31'd0, rem_ff[33:0], 1'b0};
                  quo_in = {quo_ff[31:0], 1'b0};
               end
               cnt_in = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  axis_in = 2'd0; mstart_in = 1'b1; state_in = ST_SCALE;
                  cnt_in = 6'd63;
               end
            end
         end
         ST_SCALE: begin
            if (mdone) begin
               unique case (axis_ff)
                  2'd0:    kx_in = shifted;
                  2'd1:    ky_in = shifted;
                  default: kz_in = shifted;
               endcase
               if (axis_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  mstart_in = 1'b1;
               end
            end
         end
         ST_DONE: begin
            rspv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kx_ff <= '0; ky_ff <= '0; kz_ff <= '0; kr_ff <= '0;
         mind_ff <= MinDistWidth'(1);
         rspv_ff <= 1'b0;
         mstart_ff <= 1'b0;
         cnt_ff <= '0;
         axis_ff <= '0;
      end else begin
         state_ff <= state_in;
         kx_ff <= kx_in; ky_ff <= ky_in; kz_ff <= kz_in; kr_ff <= kr_in;
         if (csr_write) mind_ff <= csr_wdata;
         rspv_ff <= rspv_in;
         mstart_ff <= mstart_in;
         cnt_ff <= (state_ff == ST_SQRT && cnt_ff == 6'd1) ? 6'd0 : cnt_in;
         axis_ff <= axis_in;
      end
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in; nr_ff <= nr_in;
      ssum_ff <= ssum_in; rem_ff <= rem_in; root_ff <= root_in; quo_ff <= quo_in;
      rsum_ff <= rsum_in;
   end

   assign req_ready = (state_ff == ST_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_data.merged_x = kx_ff[31:0];
   assign rsp_data.merged_y = ky_ff[31:0];
   assign rsp_data.merged_z = kz_ff[31:0];
   assign rsp_data.merged_radius = kr_ff;

endmodule

>>> design/bsm_checker.sv
// Port-level checks for bounding_sphere_merge, bound to the top level.
// Depends on bsm_pkg.
module bsm_checker
   import bsm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req taken while result pending");

   a_take_then_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready && !rsp_valid)
      else $error("block idle right after accepting a word");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind bounding_sphere_merge bsm_checker u_bsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> test/bounding_sphere_merge_tb.sv
// Testbench for bounding_sphere_merge: directed and random spheres, checked against
// a behavioral merge predictor. Depends on bsm_pkg and the design sources.
`timescale 1ns / 100ps

module bounding_sphere_merge_tb;
   import bsm_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_word_type rsp_data;
   logic         csr_write;
   logic [MinDistWidth-1:0] csr_wdata;

   bounding_sphere_merge DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the kept sphere and the distance threshold
   logic signed [31:0] kept_x, kept_y, kept_z;
   logic [30:0]        kept_r;
   logic [15:0]        min_dist;

   rsp_word_type merged_queue[$];
   int mismatches;
   int hold_cycles;
   bit quiet_sender;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [32:0] floor_sqrt(logic [127:0] s);
      logic [32:0]  y;
      logic [32:0]  cand;
      logic [127:0] sq;
      y = '0;
      for (int b = 32; b >= 0; b--) begin
         cand = y | (33'd1 << b);
         sq = {95'b0, cand} * {95'b0, cand};
         if (sq <= s) y = cand;
      end
      return y;
   endfunction

   function automatic logic [32:0] move_ratio(logic [63:0] num, logic [63:0] den);
      logic [32:0] q;
      logic [63:0] rem;
      if (num >= den) return 33'h1_0000_0000;
      q = '0;
      rem = num;
      for (int i = 0; i < 32; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   // move toward the old centre, truncated toward zero
   function automatic logic signed [31:0] shift_axis(longint base, longint delta,
                                                     logic [32:0] q);
      logic [63:0]  mag;
      logic [127:0] p;
      longint       s;
      mag = delta < 0 ? -delta : delta;
      p = {64'b0, mag} * {95'b0, q};
      s = longint'(p[95:32]);
      return delta < 0 ? 32'(base - s) : 32'(base + s);
   endfunction

   function automatic rsp_word_type merge_sphere(req_word_type w);
      longint       nx, ny, nz, dx, dy, dz, rd;
      logic [63:0]  ax, ay, az, rsq, rsum, k;
      logic [127:0] dist_sq;
      logic [32:0]  span, q;
      logic [30:0]  nr;
      rsp_word_type m;
      nx = $signed(w.center_x);
      ny = $signed(w.center_y);
      nz = $signed(w.center_z);
      nr = w.sphere_radius;
      dx = longint'(kept_x) - nx;
      dy = longint'(kept_y) - ny;
      dz = longint'(kept_z) - nz;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      az = dz < 0 ? -dz : dz;
      dist_sq = {64'b0, ax} * {64'b0, ax} + {64'b0, ay} * {64'b0, ay}
              + {64'b0, az} * {64'b0, az};
      rd = longint'({33'b0, kept_r}) - longint'({33'b0, nr});
      if (rd < 0) rd = -rd;
      rsq = rd * rd;
      if (dist_sq <= {64'b0, rsq}) begin
         if (kept_r < nr) begin
            kept_r = nr;
            kept_x = 32'(nx);
            kept_y = 32'(ny);
            kept_z = 32'(nz);
         end
      end else begin
         span = floor_sqrt(dist_sq);
         rsum = ({31'b0, span} + {33'b0, nr} + {33'b0, kept_r}) >> 1;
         kept_r = rsum > 64'h7FFF_FFFF ? '1 : rsum[30:0];
         kept_x = 32'(nx);
         kept_y = 32'(ny);
         kept_z = 32'(nz);
         if (span > {17'b0, min_dist}) begin
            k = rsum >= {33'b0, nr} ? rsum - {33'b0, nr} : '0;
            q = move_ratio(k, {31'b0, span});
            kept_x = shift_axis(nx, dx, q);
            kept_y = shift_axis(ny, dy, q);
            kept_z = shift_axis(nz, dz, q);
         end
      end
      m.merged_x = kept_x;
      m.merged_y = kept_y;
      m.merged_z = kept_z;
      m.merged_radius = kept_r;
      return m;
   endfunction

   function automatic int short_gap();
      if (quiet_sender) return 0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 0;
         5, 6, 7: return $urandom_range(1, 3);
         8: return $urandom_range(4, 12);
         default: return $urandom_range(20, 60);
      endcase
   endfunction

   // drop valid right after the word is taken so it is never offered twice
   task automatic send_sphere(req_word_type w);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      merged_queue.push_back(merge_sphere(w));
      gap = short_gap();
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clock);
   endtask

   task automatic send_fields(longint x, longint y, longint z, longint r);
      req_word_type w;
      w.center_x = 32'(x);
      w.center_y = 32'(y);
      w.center_z = 32'(z);
      w.sphere_radius = 31'(r);
      send_sphere(w);
   endtask

   task automatic wait_drained();
      while (merged_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_min_distance(logic [15:0] v);
      wait_drained();
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      min_dist = v;
   endtask

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic req_word_type random_sphere(int reach);
      req_word_type w;
      longint off;
      off = longint'($urandom_range(0, reach)) - reach / 2;
      case ($urandom_range(0, 9))
         0, 1: begin
            w = 127'({$urandom, $urandom, $urandom, $urandom});
         end
         2: begin
            // coincident centres: containment either way
            w.center_x = kept_x;
            w.center_y = kept_y;
            w.center_z = kept_z;
            w.sphere_radius = 31'($urandom);
         end
         3: begin
            // tiny offsets around the threshold
            w.center_x = 32'(clamp32(longint'(kept_x) + $urandom_range(0, 8) - 4));
            w.center_y = 32'(clamp32(longint'(kept_y) + $urandom_range(0, 8) - 4));
            w.center_z = kept_z;
            w.sphere_radius = 31'($urandom_range(0, 100000));
         end
         default: begin
            w.center_x = 32'(clamp32(longint'(kept_x) + off));
            w.center_y = 32'(clamp32(longint'(kept_y) + longint'($urandom_range(0, reach))
                                     - reach / 2));
            w.center_z = 32'(clamp32(longint'(kept_z) + longint'($urandom_range(0, reach))
                                     - reach / 2));
            w.sphere_radius = 31'($urandom_range(0, reach));
         end
      endcase
      return w;
   endfunction

   task automatic run_random(int count);
      int reach;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
         reach = 1 << $urandom_range(2, 24);
         send_sphere(random_sphere(reach));
      end
      quiet_sender = 1'b0;
   endtask

   task automatic test_directed();
      send_fields(0, 0, 0, 0);                          // same point, zero radius
      send_fields(0, 0, 0, 65536);                      // input contains kept
      send_fields(100, -100, 50, 10);                   // kept contains input
      send_fields(65536 * 4, 0, 0, 65536);              // plain merge with shift
      send_fields(65536 * 4 + 1, 0, 0, 65536 * 3);      // second merge with shift
      send_fields(2147483647, 2147483647, 2147483647, 2147483647);
      send_fields(-2147483648, -2147483648, -2147483648, 2147483647); // saturate
      send_fields(-2147483648, 2147483647, 0, 0);
      send_fields(0, 0, 0, 2147483647);
      send_fields(2147483647, -2147483648, -1, 1);
      send_fields(-1, -1, -1, 0);
      send_fields(-1, -1, -1, 2147483647);
      send_fields(123456, -654321, 99999, 1);
      send_fields(123457, -654321, 99999, 1);
   endtask

   task automatic test_thresholds();
      write_min_distance(16'd0);
      send_fields(kept_x + 1, kept_y, kept_z, 0);
      run_random(280);
      write_min_distance(16'hFFFF);
      send_fields(kept_x + 65535, kept_y, kept_z, 0);
      send_fields(kept_x, kept_y + 65536, kept_z, 0);
      run_random(280);
      write_min_distance(16'($urandom));
      run_random(280);
      write_min_distance(16'd1);
      run_random(250);
   endtask

   // stall the result side long enough that the block stops taking words
   task automatic test_backpressure();
      wait_drained();
      hold_cycles = 2000;
      for (int i = 0; i < 6; i++) send_sphere(random_sphere(1 << 16));
      wait_drained();
      run_random(30);
   endtask

   // result side: random stalls with calm stretches, plus long hold-offs
   initial begin
      int stall;
      bit calm;
      rsp_ready = 1'b0;
      stall = 0;
      calm = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 499) == 0) calm = ~calm;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 4);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (merged_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_data);
         end else begin
            want = merged_queue.pop_front();
            if (rsp_data.merged_x !== want.merged_x || rsp_data.merged_y !== want.merged_y ||
                rsp_data.merged_z !== want.merged_z ||
                rsp_data.merged_radius !== want.merged_radius) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x %h y %h z %h r %h, got x %h y %h z %h r %h",
                           want.merged_x, want.merged_y, want.merged_z, want.merged_radius,
                           rsp_data.merged_x, rsp_data.merged_y, rsp_data.merged_z,
                           rsp_data.merged_radius);
            end
         end
      end
   end

   initial begin
      mismatches = 0;
      hold_cycles = 0;
      quiet_sender = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_wdata = '0;
      kept_x = '0;
      kept_y = '0;
      kept_z = '0;
      kept_r = '0;
      min_dist = 16'd1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_thresholds();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (300) @(posedge clock);
      mismatches += merged_queue.size();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
